### hdl/opt_pkg.sv
// Shared types, codes and helpers for the operator precedence table.
`timescale 1ns / 1ps

package opt_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	// Request operation codes.
	localparam logic [2:0] CMD_DEFINE  = 3'd0;
	localparam logic [2:0] CMD_PREFIX  = 3'd1;
	localparam logic [2:0] CMD_INFIX   = 3'd2;
	localparam logic [2:0] CMD_POSTFIX = 3'd3;
	localparam logic [2:0] CMD_ISOP    = 3'd4;
	localparam logic [2:0] CMD_ENUM    = 3'd5;

	// Operator type codes.
	localparam logic [2:0] KIND_XFX = 3'd0;
	localparam logic [2:0] KIND_XFY = 3'd1;
	localparam logic [2:0] KIND_YFX = 3'd2;
	localparam logic [2:0] KIND_FY  = 3'd3;
	localparam logic [2:0] KIND_FX  = 3'd4;
	localparam logic [2:0] KIND_XF  = 3'd5;
	localparam logic [2:0] KIND_YF  = 3'd6;

	// Slot numbers inside one entry.
	localparam logic [1:0] SLOT_PREFIX  = 2'd0;
	localparam logic [1:0] SLOT_INFIX   = 2'd1;
	localparam logic [1:0] SLOT_POSTFIX = 2'd2;

	localparam int SLOTS = 3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [19:0] atom_key;
		logic [10:0] precedence;
		logic [2:0]  op_kind;
		logic [7:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [10:0] prec_out;
		logic [10:0] left_arg_prec;
		logic [10:0] right_arg_prec;
		logic [2:0]  kind_out;
		logic [19:0] atom_out;
		logic        table_full;
	} rsp_t;

	// Request token that walks down the row of cells and collects its answer.
	typedef struct packed {
		logic        active;
		logic [2:0]  op;
		logic [19:0] atom;
		logic [10:0] prec;
		logic [2:0]  kind;
		logic [1:0]  slot;
		logic [6:0]  eidx;
		logic        hit;
		logic        nz;
		logic [10:0] cap_prec;
		logic [2:0]  cap_kind;
		logic [19:0] cap_atom;
	} tok_t;

	// Append command broadcast to every cell; the cell at the fill count takes it.
	typedef struct packed {
		logic        en;
		logic [19:0] atom;
		logic [10:0] prec;
		logic [2:0]  kind;
		logic [1:0]  slot;
	} app_t;

	function automatic logic [1:0] slot_of_kind(input logic [2:0] kind);
		logic [1:0] s;
		unique case (kind)
			KIND_FX, KIND_FY: s = SLOT_PREFIX;
			KIND_XFX, KIND_XFY, KIND_YFX: s = SLOT_INFIX;
			default: s = SLOT_POSTFIX;
		endcase
		return s;
	endfunction

endpackage

### hdl/opt_cell.sv
// One table cell: holds one operator entry and passes the request token on.
`timescale 1ns / 1ps

module opt_cell #(
	parameter int TABLE_DEPTH = opt_pkg::TABLE_DEPTH_DEF,
	parameter int IDX = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
	input  opt_pkg::app_t                    app,
	input  opt_pkg::tok_t                    tok_in,
	output opt_pkg::tok_t                    tok_out
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] IDX_V = CW'(IDX);
	// Enumerate reaches only the entries a 7-bit entry index can name.
	localparam bit IN_RANGE = (IDX < 128);

	logic [19:0] atom_q;
	logic [10:0] prec_q [opt_pkg::SLOTS];
	logic [2:0]  kind_q [opt_pkg::SLOTS];
	opt_pkg::tok_t tok_q;
	opt_pkg::tok_t nxt;

	logic valid_e;
	logic key_hit;
	logic enum_hit;
	logic def_wr;
	logic app_wr;

	always_comb begin
		valid_e = (IDX_V < count);
		key_hit = tok_in.active && valid_e && !tok_in.hit &&
			(tok_in.op <= opt_pkg::CMD_ISOP) && (atom_q == tok_in.atom);
		enum_hit = tok_in.active && valid_e && !tok_in.hit &&
			(tok_in.op == opt_pkg::CMD_ENUM) && IN_RANGE && (tok_in.eidx == 7'(IDX));
		def_wr = adv && key_hit && (tok_in.op == opt_pkg::CMD_DEFINE);
		app_wr = app.en && (count == IDX_V);
		nxt = tok_in;
		if (key_hit || enum_hit) begin
			nxt.hit      = 1'b1;
			nxt.cap_prec = prec_q[tok_in.slot];
			nxt.cap_kind = kind_q[tok_in.slot];
			nxt.cap_atom = atom_q;
			nxt.nz       = |{prec_q[0], prec_q[1], prec_q[2]};
		end
	end

	// Entry contents; a new entry starts with only its defined slot set, the others cleared.
	always_ff @(posedge clk) begin
		if (def_wr) begin
			prec_q[tok_in.slot] <= tok_in.prec;
			kind_q[tok_in.slot] <= tok_in.kind;
		end else if (app_wr) begin
			atom_q <= app.atom;
			for (int i = 0; i < opt_pkg::SLOTS; i++) begin
				if (app.slot == 2'(i)) begin
					prec_q[i] <= app.prec;
					kind_q[i] <= app.kind;
				end else begin
					prec_q[i] <= '0;
					kind_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

### hdl/operator_precedence_table.sv
// Top level of the operator precedence table: request intake, cell row and result stage.
`timescale 1ns / 1ps

//  channel | ports                        | moves
//  --------+------------------------------+--------------------------------------
//  request | req_valid, req_stall, req    | one item: operation, atom, prec, kind, slot index
//  result  | rsp_valid, rsp_stall, rsp    | one item per request
//
// Each request passes from acceptance to a ready result through the intake
// register and then the register in each cell of the row, since the token
// must visit every entry to search for its atom. The next request is accepted
// in the cycle after the result is loaded, so the block never holds more than
// one request at a time.
// Reset empties the table at once (the fill count goes to zero); no sweep.
// A held result stalls the row only when a finished token reaches its end.

module operator_precedence_table #(
	parameter int TABLE_DEPTH = opt_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  opt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output opt_pkg::rsp_t rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic          busy_q;
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	opt_pkg::rsp_t rsp_q;
	opt_pkg::tok_t head_q;
	opt_pkg::tok_t new_tok;
	opt_pkg::tok_t tail;
	opt_pkg::tok_t chain [TABLE_DEPTH+1];
	opt_pkg::app_t app;
	opt_pkg::rsp_t res;

	logic          adv;
	logic          full;
	logic          accept;
	logic [15:0]   quot_prod;
	logic [6:0]    eidx;
	logic [7:0]    rem;
	logic [10:0]   p;
	logic [10:0]   pm1;

	assign accept    = req_valid && !busy_q;
	assign req_stall = busy_q;
	assign tail      = chain[TABLE_DEPTH];
	assign full      = (count_q == CW'(TABLE_DEPTH));

	// The row moves every cycle unless a finished token cannot leave.
	assign adv = !(tail.active && rsp_valid_q && rsp_stall);

	// Build the token. Slot index / 3 uses the reciprocal 171/512, exact for 8 bits.
	always_comb begin
		quot_prod = 16'(req.slot_index) * 16'd171;
		eidx      = quot_prod[15:9];
		rem       = 8'(req.slot_index - 8'(8'(eidx) * 8'd3));
		new_tok          = '0;
		new_tok.active   = 1'b1;
		new_tok.op       = req.operation;
		new_tok.atom     = req.atom_key;
		new_tok.prec     = req.precedence;
		new_tok.kind     = req.op_kind;
		new_tok.eidx     = eidx;
		unique case (req.operation)
			opt_pkg::CMD_DEFINE:  new_tok.slot = opt_pkg::slot_of_kind(req.op_kind);
			opt_pkg::CMD_PREFIX:  new_tok.slot = opt_pkg::SLOT_PREFIX;
			opt_pkg::CMD_INFIX:   new_tok.slot = opt_pkg::SLOT_INFIX;
			opt_pkg::CMD_POSTFIX: new_tok.slot = opt_pkg::SLOT_POSTFIX;
			opt_pkg::CMD_ENUM:    new_tok.slot = rem[1:0];
			default:              new_tok.slot = opt_pkg::SLOT_PREFIX;
		endcase
	end

	assign chain[0] = head_q;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		opt_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.count(count_q),
			.app(app),
			.tok_in(chain[g]),
			.tok_out(chain[g+1])
		);
	end

	// A define that found no entry appends one at the fill count, if there is room.
	always_comb begin
		app.en   = adv && tail.active && (tail.op == opt_pkg::CMD_DEFINE) && !tail.hit && !full;
		app.atom = tail.atom;
		app.prec = tail.prec;
		app.kind = tail.kind;
		app.slot = tail.slot;
	end

	// Turn the finished token into a result item.
	always_comb begin
		p   = tail.cap_prec;
		pm1 = 11'(p - 11'd1);
		res = '0;
		unique case (tail.op)
			opt_pkg::CMD_DEFINE: begin
				res.table_full = !tail.hit && full;
			end
			opt_pkg::CMD_PREFIX: begin
				if (tail.hit && (p != '0)) begin
					res.found          = 1'b1;
					res.prec_out       = p;
					res.right_arg_prec = (tail.cap_kind == opt_pkg::KIND_FY) ? p : pm1;
				end
			end
			opt_pkg::CMD_INFIX: begin
				if (tail.hit && (p != '0)) begin
					res.found          = 1'b1;
					res.prec_out       = p;
					res.left_arg_prec  = (tail.cap_kind == opt_pkg::KIND_YFX) ? p : pm1;
					res.right_arg_prec = (tail.cap_kind == opt_pkg::KIND_XFY) ? p : pm1;
				end
			end
			opt_pkg::CMD_POSTFIX: begin
				if (tail.hit && (p != '0)) begin
					res.found         = 1'b1;
					res.prec_out      = p;
					res.left_arg_prec = (tail.cap_kind == opt_pkg::KIND_YF) ? p : pm1;
				end
			end
			opt_pkg::CMD_ISOP: begin
				res.found = tail.hit && tail.nz;
			end
			opt_pkg::CMD_ENUM: begin
				if (tail.hit) begin
					res.found    = 1'b1;
					res.prec_out = p;
					res.kind_out = tail.cap_kind;
					res.atom_out = tail.cap_atom;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q <= new_tok;
				busy_q <= 1'b1;
			end else if (adv) begin
				head_q.active <= 1'b0;
			end
			if (adv && tail.active) begin
				rsp_valid_q <= 1'b1;
				busy_q      <= 1'b0;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (app.en) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail.active) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### verif/operator_precedence_table_test.sv
// Self-checking testbench for the operator precedence table: directed and random requests.
`timescale 1ns / 1ps

// The bench drives requests into the table, one item per handshake.
// A shadow copy of the table predicts every result at the moment its request is accepted.
// The checker compares each accepted result with the oldest prediction, field by field.
// The block serves one request at a time, so predictions queue up strictly in order.
module operator_precedence_table_test;

	localparam int DEPTH         = opt_pkg::TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = DEPTH + 16;
	localparam int POOL_SIZE     = 24;
	localparam int LONG_HOLD     = 600;

	// Operation codes the block must ignore, and the type code outside the named set.
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam logic [2:0] KIND_CODE_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	opt_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	opt_pkg::rsp_t rsp;

	// Shadow table. Only entries below shadow_count are ever looked at.
	logic [19:0] shadow_atom [DEPTH];
	logic [10:0] shadow_prec [DEPTH][opt_pkg::SLOTS];
	logic [2:0]  shadow_kind [DEPTH][opt_pkg::SLOTS];
	int          shadow_count;

	opt_pkg::rsp_t pending_rsp_q[$];
	logic [19:0] atom_pool[POOL_SIZE];
	int          errors;
	int unsigned cycles = 0;
	bit          no_idle;
	int          hold_cycles;

	always #5 clk = ~clk;

	operator_precedence_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// Returns the entry that holds the atom, or -1 when the atom has no entry yet.
	function automatic int find_atom(logic [19:0] atom);
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_atom[i] == atom)
				return i;
		end
		return -1;
	endfunction

	// Prefix types go to slot 0 and infix types to slot 1.
	// Everything else, the unnamed code 7 included, lands in the postfix slot.
	function automatic int slot_for_kind(logic [2:0] kind);
		if (kind == opt_pkg::KIND_FX || kind == opt_pkg::KIND_FY)
			return opt_pkg::SLOT_PREFIX;
		if (kind == opt_pkg::KIND_XFX || kind == opt_pkg::KIND_XFY ||
				kind == opt_pkg::KIND_YFX)
			return opt_pkg::SLOT_INFIX;
		return opt_pkg::SLOT_POSTFIX;
	endfunction

	// Applies one request to the shadow table and returns the result the block must give.
	function automatic opt_pkg::rsp_t apply_request(opt_pkg::req_t r);
		opt_pkg::rsp_t res;
		int e;
		int s;
		logic [10:0] p;
		logic [2:0] t;
		res = '0;
		case (r.operation)
			opt_pkg::CMD_DEFINE: begin
				s = slot_for_kind(r.op_kind);
				e = find_atom(r.atom_key);
				if (e < 0 && shadow_count >= DEPTH) begin
					// A new atom on a full table is refused, even with zero precedence.
					res.table_full = 1'b1;
				end else begin
					if (e < 0) begin
						e = shadow_count;
						shadow_atom[e] = r.atom_key;
						for (int j = 0; j < opt_pkg::SLOTS; j++) begin
							shadow_prec[e][j] = '0;
							shadow_kind[e][j] = '0;
						end
						shadow_count++;
					end
					shadow_prec[e][s] = r.precedence;
					shadow_kind[e][s] = r.op_kind;
				end
			end
			opt_pkg::CMD_PREFIX, opt_pkg::CMD_INFIX, opt_pkg::CMD_POSTFIX: begin
				s = int'(r.operation - opt_pkg::CMD_PREFIX);
				e = find_atom(r.atom_key);
				if (e >= 0 && shadow_prec[e][s] != 0) begin
					p = shadow_prec[e][s];
					t = shadow_kind[e][s];
					res.found = 1'b1;
					res.prec_out = p;
					// A y side allows the full precedence, an x side one less.
					if (s == opt_pkg::SLOT_PREFIX) begin
						res.right_arg_prec = (t == opt_pkg::KIND_FY) ? p : p - 11'd1;
					end else if (s == opt_pkg::SLOT_INFIX) begin
						res.left_arg_prec  = (t == opt_pkg::KIND_YFX) ? p : p - 11'd1;
						res.right_arg_prec = (t == opt_pkg::KIND_XFY) ? p : p - 11'd1;
					end else begin
						res.left_arg_prec  = (t == opt_pkg::KIND_YF) ? p : p - 11'd1;
					end
				end
			end
			opt_pkg::CMD_ISOP: begin
				e = find_atom(r.atom_key);
				if (e >= 0 && (shadow_prec[e][opt_pkg::SLOT_PREFIX] |
						shadow_prec[e][opt_pkg::SLOT_INFIX] |
						shadow_prec[e][opt_pkg::SLOT_POSTFIX]) != 0)
					res.found = 1'b1;
			end
			opt_pkg::CMD_ENUM: begin
				e = r.slot_index / opt_pkg::SLOTS;
				s = r.slot_index % opt_pkg::SLOTS;
				if (e < shadow_count) begin
					res.found    = 1'b1;
					res.prec_out = shadow_prec[e][s];
					res.kind_out = shadow_kind[e][s];
					res.atom_out = shadow_atom[e];
				end
			end
			default: begin
				// The spare codes leave the table alone and answer with all zeros.
			end
		endcase
		return res;
	endfunction

	function automatic opt_pkg::req_t make_request(logic [2:0] operation, logic [19:0] atom,
			logic [10:0] prec, logic [2:0] kind, logic [7:0] index);
		opt_pkg::req_t r;
		r.operation  = operation;
		r.atom_key   = atom;
		r.precedence = prec;
		r.op_kind    = kind;
		r.slot_index = index;
		return r;
	endfunction

	// Most requests work on a small pool of atoms so that defines and queries meet.
	// A few use fresh keys, spare codes or out-of-range values as noise.
	function automatic opt_pkg::req_t random_request();
		opt_pkg::req_t r;
		int pick;
		int top_index;
		r.atom_key = ($urandom_range(0, 9) == 0) ? 20'($urandom) :
			atom_pool[$urandom_range(0, POOL_SIZE - 1)];
		pick = $urandom_range(0, 9);
		if (pick == 0)
			r.precedence = '0;
		else if (pick == 1)
			r.precedence = 11'($urandom_range(1201, 2047));
		else if (pick == 2)
			r.precedence = $urandom_range(0, 1) ? 11'd1 : 11'd1200;
		else
			r.precedence = 11'($urandom_range(1, 1200));
		r.op_kind = ($urandom_range(0, 15) == 0) ? KIND_CODE_7 : 3'($urandom_range(0, 6));
		top_index = shadow_count * opt_pkg::SLOTS + 2;
		if (top_index > 255)
			top_index = 255;
		r.slot_index = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
			8'($urandom_range(0, top_index));
		pick = $urandom_range(0, 99);
		if (pick < 30)
			r.operation = opt_pkg::CMD_DEFINE;
		else if (pick < 70)
			r.operation = 3'($urandom_range(opt_pkg::CMD_PREFIX, opt_pkg::CMD_POSTFIX));
		else if (pick < 80)
			r.operation = opt_pkg::CMD_ISOP;
		else if (pick < 94)
			r.operation = opt_pkg::CMD_ENUM;
		else if (pick < 97)
			r.operation = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
		else
			r.operation = 3'($urandom_range(0, 7));
		return r;
	endfunction

	// Offers one item after a random gap and records its prediction once it is taken.
	// Valid is only lowered when a gap follows, so back-to-back items keep it high.
	task automatic send_item(opt_pkg::req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			req <= random_request();
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!(req_valid && !req_stall));
		pending_rsp_q.push_back(apply_request(r));
	endtask

	// The last item is withdrawn first so that it is not taken a second time.
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string name, logic [19:0] want, logic [19:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// Hand-picked requests: the empty table, field extremes, every type and
	// both argument sides, zero precedence, type code 7, precedence above 1200,
	// enumerate past the end, and the spare operation codes.
	task automatic test_directed_cases();
		send_item(make_request(opt_pkg::CMD_PREFIX, 20'h5, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_ENUM, 20'h0, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_DEFINE, 20'h0, 11'd1200, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_DEFINE, 20'h0, 11'd1, opt_pkg::KIND_FY, 8'd0));
		send_item(make_request(opt_pkg::CMD_DEFINE, 20'h0, 11'h7FF, KIND_CODE_7, 8'hFF));
		send_item(make_request(opt_pkg::CMD_PREFIX, 20'h0, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_INFIX, 20'h0, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_POSTFIX, 20'h0, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_ISOP, 20'h0, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		// Zero precedence still creates the entry, but the atom is no operator yet.
		send_item(make_request(opt_pkg::CMD_DEFINE, 20'hFFFFF, 11'd0, opt_pkg::KIND_XFY, 8'd0));
		send_item(make_request(opt_pkg::CMD_ISOP, 20'hFFFFF, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_INFIX, 20'hFFFFF, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_DEFINE, 20'hFFFFF, 11'd700, opt_pkg::KIND_YFX,
			8'd0));
		send_item(make_request(opt_pkg::CMD_INFIX, 20'hFFFFF, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_DEFINE, 20'hFFFFF, 11'd200, opt_pkg::KIND_YF, 8'd0));
		send_item(make_request(opt_pkg::CMD_POSTFIX, 20'hFFFFF, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_DEFINE, 20'hFFFFF, 11'd1, opt_pkg::KIND_XF, 8'd0));
		send_item(make_request(opt_pkg::CMD_POSTFIX, 20'hFFFFF, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_DEFINE, 20'hFFFFF, 11'd900, opt_pkg::KIND_FX, 8'd0));
		send_item(make_request(opt_pkg::CMD_PREFIX, 20'hFFFFF, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_DEFINE, 20'hFFFFF, 11'd1100, opt_pkg::KIND_XFY,
			8'd0));
		send_item(make_request(opt_pkg::CMD_INFIX, 20'hFFFFF, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_ENUM, 20'h0, 11'd0, opt_pkg::KIND_XFX, 8'd5));
		send_item(make_request(opt_pkg::CMD_ENUM, 20'h0, 11'd0, opt_pkg::KIND_XFX, 8'd6));
		send_item(make_request(opt_pkg::CMD_ENUM, 20'h0, 11'd0, opt_pkg::KIND_XFX, 8'hFF));
		send_item(make_request(CMD_SPARE_6, 20'hFFFFF, 11'h7FF, KIND_CODE_7, 8'hFF));
		send_item(make_request(CMD_SPARE_7, 20'h0, 11'd1200, opt_pkg::KIND_FY, 8'd1));
	endtask

	task automatic test_random(int count);
		repeat (count) send_item(random_request());
	endtask

	// Neither side idles here, so the block runs at its full rate.
	task automatic test_no_idle_stretch();
		no_idle = 1'b1;
		test_random(40);
		no_idle = 1'b0;
	endtask

	// Fills the table with fresh atoms, then tries to add more.
	task automatic test_table_fill();
		logic [19:0] atom;
		while (shadow_count < DEPTH) begin
			do
				atom = 20'($urandom);
			while (find_atom(atom) >= 0);
			send_item(make_request(opt_pkg::CMD_DEFINE, atom, 11'($urandom_range(1, 1200)),
				3'($urandom_range(0, 6)), 8'd0));
		end
		repeat (4) begin
			do
				atom = 20'($urandom);
			while (find_atom(atom) >= 0);
			send_item(make_request(opt_pkg::CMD_DEFINE, atom, 11'($urandom_range(0, 2047)),
				3'($urandom_range(0, 7)), 8'd0));
		end
		// A refused define with zero precedence must be refused just the same.
		send_item(make_request(opt_pkg::CMD_DEFINE, atom, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_ISOP, atom, 11'd0, opt_pkg::KIND_XFX, 8'd0));
		send_item(make_request(opt_pkg::CMD_DEFINE, shadow_atom[DEPTH - 1], 11'd500,
			opt_pkg::KIND_FY, 8'd0));
		send_item(make_request(opt_pkg::CMD_ENUM, 20'h0, 11'd0, opt_pkg::KIND_XFX,
			8'(DEPTH * opt_pkg::SLOTS - 1)));
		send_item(make_request(opt_pkg::CMD_ENUM, 20'h0, 11'd0, opt_pkg::KIND_XFX,
			8'(DEPTH * opt_pkg::SLOTS)));
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the
	// block backs up and stalls its input. Then the sender waits for every result.
	task automatic test_backpressure();
		wait_drained();
		hold_cycles = LONG_HOLD;
		no_idle = 1'b1;
		test_random(8);
		no_idle = 1'b0;
		wait_drained();
	endtask

	// Result side: a random hold-off before each item, or the long one when asked.
	initial begin : result_receiver
		int n;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 9);
			end
			if (n > 0) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			@(negedge clk);
			rsp_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(rsp_valid && !rsp_stall));
		end
	end

	always @(posedge clk) begin : result_check
		opt_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: expected nothing, actual %p",
					$time, rsp);
			end else begin
				want = pending_rsp_q.pop_front();
				check_field("found", want.found, rsp.found);
				check_field("prec_out", want.prec_out, rsp.prec_out);
				check_field("left_arg_prec", want.left_arg_prec, rsp.left_arg_prec);
				check_field("right_arg_prec", want.right_arg_prec, rsp.right_arg_prec);
				check_field("kind_out", want.kind_out, rsp.kind_out);
				check_field("atom_out", want.atom_out, rsp.atom_out);
				check_field("table_full", want.table_full, rsp.table_full);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_rsp_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : main_sequence
		int i;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		no_idle = 1'b0;
		hold_cycles = 0;
		errors = 0;
		shadow_count = 0;
		for (i = 0; i < POOL_SIZE; i++)
			atom_pool[i] = 20'($urandom);
		atom_pool[0] = 20'h0;
		atom_pool[1] = 20'hFFFFF;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random(150);
		test_no_idle_stretch();
		test_table_fill();
		test_backpressure();
		test_random(150);

		@(negedge clk);
		req_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_rsp_q.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_rsp_q.size());
		end
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
